### hdl/hermite_segment_coefficients_top_assert.svh
// Assertion macros for the Hermite segment coefficient block.
// Included by the checker module; depends on nothing else.
`ifndef HERMITE_SEGMENT_COEFFICIENTS_TOP_ASSERT_SVH
`define HERMITE_SEGMENT_COEFFICIENTS_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define HSC_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define HSC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### hdl/hsc_pkg.sv
// Package for the Hermite segment coefficient block: widths, types, helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hsc_pkg;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int TEN_W   = 16;
    localparam int COEF_W  = 40;
    localparam int SQ_W    = 66;   // exact sum of three squared 33-bit diffs
    localparam int ROOT_W  = 33;
    localparam int ACC_W   = 72;   // working width of coefficient math

    localparam logic [1:0] ROW_X     = 2'd0;
    localparam logic [1:0] ROW_Y     = 2'd1;
    localparam logic [1:0] ROW_Z     = 2'd2;
    localparam logic [1:0] ROW_WIDTH = 2'd3;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,      // capture item, compute diffs
        CMD_SQUARE,    // square diff[idx] and accumulate
        CMD_ROOT_INIT,
        CMD_ROOT_STEP,
        CMD_TD0,
        CMD_TD1,
        CMD_M0,        // m0 for row idx
        CMD_M1,        // m1 for row idx
        CMD_ROW,       // form and register output row idx
        CMD_STORE      // current point becomes previous
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] idx;
    } ctrl_t;

    typedef struct packed {
        logic have_prev;
        logic start;
    } stat_t;

    function automatic logic [COEF_W-1:0] sat_coef(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] lim;
        logic [COEF_W-1:0]       r;
        lim = ACC_W'((72'sd1 <<< (COEF_W - 1)) - 72'sd1);
        if (v > lim)
            r = {1'b0, {(COEF_W-1){1'b1}}};
        else if (v < -lim - 72'sd1)
            r = {1'b1, {(COEF_W-1){1'b0}}};
        else
            r = v[COEF_W-1:0];
        return r;
    endfunction

endpackage

### hdl/hsc_datapath.sv
// Datapath: previous point store, squared distance, iterative root,
// tangent multiplies and coefficient rows. Depends on hsc_pkg.
`timescale 1ns / 1ps

module hsc_datapath
    import hsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    input  logic [255:0]      in_data,
    output stat_t             stat,
    output logic [1:0]        row_select,
    output logic [COEF_W-1:0] coef_const,
    output logic [COEF_W-1:0] coef_linear,
    output logic [COEF_W-1:0] coef_square,
    output logic [COEF_W-1:0] coef_cube
);

    logic signed [COORD_W-1:0] prev_pos_reg [3];
    logic signed [DIR_W-1:0]   prev_dir_reg [3];
    logic [TEN_W-1:0]          prev_ten_reg;
    logic signed [COORD_W-1:0] prev_w_reg, prev_s_reg;
    logic                      have_prev_reg;

    logic signed [COORD_W-1:0] cur_pos_reg [3];
    logic signed [DIR_W-1:0]   cur_dir_reg [3];
    logic [TEN_W-1:0]          cur_ten_reg;
    logic signed [COORD_W-1:0] cur_w_reg, cur_s_reg;
    logic                      start_reg;

    logic signed [COORD_W:0]   diff_reg [3];
    logic [SQ_W-1:0]           sum_reg;
    logic [SQ_W-1:0]           rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [5:0]                rcnt_reg;
    logic signed [51:0]        td0_reg, td1_reg;
    logic signed [ACC_W-1:0]   m0_reg, m1_reg;

    logic signed [COORD_W:0]   dsel;
    logic [COORD_W-1:0]        mag;
    logic [2*COORD_W-1:0]      sq;
    logic [SQ_W-1:0]           trial;
    logic [SQ_W-1:0]           rem_sh;
    logic [ROOT_W-1:0]         r_sh;
    logic [TEN_W-1:0]          tsel;
    logic [ROOT_W+TEN_W:0]     tprod;
    logic signed [51:0]        tdsel;
    logic signed [DIR_W-1:0]   dirsel;
    logic signed [51+DIR_W:0]  mfull;
    logic signed [ACC_W-1:0]   mprod;
    logic signed [ACC_W-1:0]   p, c0, c1, c2, c3;

    assign stat.have_prev = have_prev_reg;
    assign stat.start     = start_reg;

    always_comb
    begin
        dsel   = diff_reg[ctrl.idx == 2'd3 ? 2'd0 : ctrl.idx];
        mag    = dsel[COORD_W] ? COORD_W'(-dsel) : dsel[COORD_W-1:0];
        if (dsel == -(33'sd1 <<< 32))
            mag = '1;
        sq     = mag * mag;
        rem_sh = {rem_reg[SQ_W-3:0], sum_reg[SQ_W-1 - 2*rcnt_reg[5:0] -: 2]};
        trial  = {31'd0, root_reg, 2'b01};
        r_sh   = {root_reg[ROOT_W-2:0], 1'b0};
        tsel   = (ctrl.cmd == CMD_TD0) ? prev_ten_reg : cur_ten_reg;
        tprod  = {1'b0, root_reg} * {1'b0, tsel};
        tdsel  = (ctrl.cmd == CMD_M0) ? td0_reg : td1_reg;
        dirsel = (ctrl.cmd == CMD_M0) ? prev_dir_reg[ctrl.idx == 2'd3 ? 2'd0 : ctrl.idx]
                                      : cur_dir_reg[ctrl.idx == 2'd3 ? 2'd0 : ctrl.idx];
        mfull  = tdsel * dirsel;
        mprod  = ACC_W'(mfull) + (ACC_W'(1) <<< 13);
        if (ctrl.idx == ROW_WIDTH)
        begin
            p  = ACC_W'(cur_w_reg) - ACC_W'(prev_w_reg);
            c0 = ACC_W'(prev_w_reg);
            c1 = ACC_W'(prev_s_reg);
            c3 = ACC_W'(cur_s_reg) - (p <<< 1) + ACC_W'(prev_s_reg);
        end
        else
        begin
            p  = ACC_W'(diff_reg[ctrl.idx]);
            c0 = ACC_W'(prev_pos_reg[ctrl.idx]);
            c1 = m0_reg;
            c3 = m1_reg - (p <<< 1) + m0_reg;
        end
        c2 = p - c1 - c3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prev_pos_reg[i] <= '0;
                prev_dir_reg[i] <= '0;
            end
            prev_ten_reg  <= '0;
            prev_w_reg    <= '0;
            prev_s_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (ctrl.cmd == CMD_STORE)
        begin
            prev_pos_reg  <= cur_pos_reg;
            prev_dir_reg  <= cur_dir_reg;
            prev_ten_reg  <= cur_ten_reg;
            prev_w_reg    <= cur_w_reg;
            prev_s_reg    <= cur_s_reg;
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            CMD_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cur_pos_reg[i] <= in_data[32*i +: 32];
                    cur_dir_reg[i] <= in_data[96 + 16*i +: 16];
                    diff_reg[i]    <= (COORD_W+1)'(signed'(in_data[32*i +: 32]))
                                      - (COORD_W+1)'(prev_pos_reg[i]);
                end
                cur_ten_reg <= in_data[159:144];
                cur_w_reg   <= in_data[191:160];
                cur_s_reg   <= in_data[223:192];
                start_reg   <= in_data[224];
                sum_reg     <= '0;
            end
            CMD_SQUARE:
                sum_reg <= sum_reg + SQ_W'(sq);
            CMD_ROOT_INIT:
            begin
                rem_reg  <= '0;
                root_reg <= '0;
                rcnt_reg <= '0;
            end
            CMD_ROOT_STEP:
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= r_sh | ROOT_W'(1);
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= r_sh;
                end
                rcnt_reg <= rcnt_reg + 6'd1;
            end
            CMD_TD0: td0_reg <= 52'(signed'({1'b0, tprod} + 51'd128) >>> 8);
            CMD_TD1: td1_reg <= 52'(signed'({1'b0, tprod} + 51'd128) >>> 8);
            CMD_M0:  m0_reg  <= mprod >>> 14;
            CMD_M1:  m1_reg  <= mprod >>> 14;
            CMD_ROW:
            begin
                row_select  <= ctrl.idx;
                coef_const  <= sat_coef(c0);
                coef_linear <= sat_coef(c1);
                coef_square <= sat_coef(c2);
                coef_cube   <= sat_coef(c3);
            end
            default: ;
        endcase
    end

endmodule

### hdl/hsc_control.sv
// Sequencer for one control point: squares, root iterations, tangents, rows.
// Depends on hsc_pkg.
`timescale 1ns / 1ps

module hsc_control
    import hsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_ready,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  in_ready,
    output logic  out_valid,
    output logic  out_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SQ, S_RINIT, S_ROOT, S_TD0, S_TD1, S_M0, S_M1, S_ROW,
        S_OUT, S_STORE
    } state_t;

    state_t     state_reg;
    logic [1:0] idx_reg;
    logic [5:0] cnt_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctrl.idx = idx_reg;
        unique case (state_reg)
            S_LOAD:  ctrl.cmd = CMD_LOAD;
            S_SQ:    ctrl.cmd = CMD_SQUARE;
            S_RINIT: ctrl.cmd = CMD_ROOT_INIT;
            S_ROOT:  ctrl.cmd = CMD_ROOT_STEP;
            S_TD0:   ctrl.cmd = CMD_TD0;
            S_TD1:   ctrl.cmd = CMD_TD1;
            S_M0:    ctrl.cmd = CMD_M0;
            S_M1:    ctrl.cmd = CMD_M1;
            S_ROW:   ctrl.cmd = CMD_ROW;
            S_STORE: ctrl.cmd = CMD_STORE;
            default: ctrl.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            out_valid <= 1'b0;
            out_last  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (in_fire) state_reg <= S_LOAD;
                S_LOAD:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (!stat.have_prev || stat.start)
                        state_reg <= S_STORE;
                    else if (idx_reg == 2'd2)
                        state_reg <= S_RINIT;
                    idx_reg <= idx_reg + 2'd1;
                end
                S_RINIT: state_reg <= S_ROOT;
                S_ROOT:
                begin
                    if (cnt_reg == 6'd32)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_TD0;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_TD0: state_reg <= S_TD1;
                S_TD1:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_M0;
                end
                S_M0: state_reg <= (idx_reg == ROW_WIDTH) ? S_ROW : S_M1;
                S_M1: state_reg <= S_ROW;
                S_ROW:
                begin
                    out_valid <= 1'b1;
                    out_last  <= (idx_reg == ROW_WIDTH);
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= (idx_reg == ROW_WIDTH) ? S_STORE : S_M0;
                    end
                S_STORE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/hermite_segment_coefficients_top.sv
// Top level of the cubic Hermite segment coefficient block.
// Depends on hsc_pkg, hsc_control and hsc_datapath.
`timescale 1ns / 1ps

// One control point per input transaction. A point that starts a curve (or
// the first point after reset) is only stored. Any other point yields four
// output transactions (rows x, y, z, width), and output stalls hold it up:
// square-accumulate of the three diffs on a shared 32x32 multiplier, 33 steps
// of the bit-pair square-root loop, two tension multiplies, then per row the
// tangent multiplies and one output beat.
// The next point is taken only after the last row is delivered.
module hermite_segment_coefficients_top
    import hsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, tension, width, spread
    input  logic [223:0] s_tdata,
    // curve_start
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // coef_const, coef_linear, coef_square, coef_cube
    output logic [159:0] m_tdata,
    // row_select
    output logic [1:0]   m_tuser,
    // last_row
    output logic         m_tlast
);

    ctrl_t ctrl;
    stat_t stat;
    logic [COEF_W-1:0] c0, c1, c2, c3;

    hsc_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && s_tready),
        .out_ready(m_tready), .stat(stat), .ctrl(ctrl), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_last(m_tlast)
    );

    // hold the input payload until the load step captures it
    logic [224:0] hold_reg;
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            hold_reg <= {s_tuser, s_tdata};
    end

    hsc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .in_data({31'd0, hold_reg}),
        .stat(stat), .row_select(m_tuser), .coef_const(c0), .coef_linear(c1),
        .coef_square(c2), .coef_cube(c3)
    );

    assign m_tdata = {c3, c2, c1, c0};

endmodule

### hdl/hsc_checker.sv
// Port-level checker for the Hermite segment coefficient block, bound to top.
// Depends on hsc_pkg and hermite_segment_coefficients_top_assert.svh.
`timescale 1ns / 1ps
`include "hermite_segment_coefficients_top_assert.svh"

module hsc_checker
    import hsc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [1:0]   m_tuser,
    input logic         m_tlast,
    input logic [159:0] m_tdata
);

    `HSC_ASSERT_IMPL(a_no_overlap, clk, rst_n, m_tvalid, !s_tready)
    `HSC_ASSERT_IMPL(a_last_row, clk, rst_n, m_tvalid, m_tlast == (m_tuser == ROW_WIDTH))
    `HSC_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind hermite_segment_coefficients_top hsc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast), .m_tdata(m_tdata)
);

### dv/tb_top.sv
// Self-checking testbench for hermite_segment_coefficients_top.
// Drives control points on the input stream and compares emitted coefficient rows with an
// in-bench predictor of the segment math. Depends on hsc_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;
    import hsc_pkg::*;

    typedef struct packed {
        logic        curve_start;
        logic [31:0] spread;
        logic [31:0] width;
        logic [15:0] tension;
        logic [15:0] dir_z;
        logic [15:0] dir_y;
        logic [15:0] dir_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } point_t;

    typedef struct packed {
        logic [1:0]        row;
        logic [COEF_W-1:0] c0;
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic              last;
    } row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM     = 95;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    hermite_segment_coefficients_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    point_t pending_points[$];
    row_t   expected_rows[$];
    int     error_count;
    int     rows_seen;
    int     points_sent;
    int     segments_sent;
    int     idle_cycles;
    bit     stim_done;
    bit     calm_phase;     // last part of the run: no idling on either side

    // Predictor state: the previous point of the current curve
    logic signed [31:0] last_pos [3];
    logic signed [15:0] last_dir [3];
    logic        [15:0] last_ten;
    logic signed [31:0] last_wid;
    logic signed [31:0] last_spr;
    bit                 have_last;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("MISMATCH row %0d %s: got %h want %h", rows_seen, what, got, want);
    endtask

    // Floor shift with round-to-nearest, ties toward plus infinity
    function automatic logic signed [95:0] round_down(input logic signed [95:0] v,
                                                      input int s);
        logic signed [95:0] b;
        b = v + (96'sd1 <<< (s - 1));
        return b >>> s;
    endfunction

    function automatic logic [COEF_W-1:0] clip_coef(input logic signed [95:0] v);
        logic signed [95:0] hi_lim;
        logic signed [95:0] lo_lim;
        hi_lim = (96'sd1 <<< (COEF_W - 1)) - 96'sd1;
        lo_lim = -(96'sd1 <<< (COEF_W - 1));
        if (v > hi_lim) return hi_lim[COEF_W-1:0];
        if (v < lo_lim) return lo_lim[COEF_W-1:0];
        return v[COEF_W-1:0];
    endfunction

    // Work out the rows a point causes and advance the stored previous point
    task automatic predict_segment(input point_t p);
        logic signed [31:0] cur_pos [3];
        logic signed [15:0] cur_dir [3];
        logic        [67:0] dist_sq;
        logic        [67:0] rem;
        logic        [67:0] root;
        logic        [67:0] bitv;
        logic signed [95:0] diff, td0, td1, m0, m1, cube, dw;
        logic signed [95:0] c [4];
        row_t r;
        cur_pos[0] = p.pos_x; cur_pos[1] = p.pos_y; cur_pos[2] = p.pos_z;
        cur_dir[0] = p.dir_x; cur_dir[1] = p.dir_y; cur_dir[2] = p.dir_z;
        if (have_last && !p.curve_start)
        begin
            dist_sq = '0;
            for (int i = 0; i < 3; i++)
            begin
                diff = 96'(cur_pos[i]) - 96'(last_pos[i]);
                dist_sq += 68'(diff * diff);
            end
            // bit-pair integer square root, truncated
            rem = dist_sq; root = '0; bitv = 68'd1 << 66;
            while (bitv > rem) bitv >>= 2;
            while (bitv != 0)
            begin
                if (rem >= root + bitv)
                begin
                    rem -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            td0 = round_down($signed({28'd0, last_ten}) * $signed({28'd0, root}), 8);
            td1 = round_down($signed({28'd0, p.tension}) * $signed({28'd0, root}), 8);
            for (int i = 0; i < 3; i++)
            begin
                diff = 96'(cur_pos[i]) - 96'(last_pos[i]);
                m0   = round_down(td0 * 96'(last_dir[i]), 14);
                m1   = round_down(td1 * 96'(cur_dir[i]), 14);
                cube = m1 - 2 * diff + m0;
                r.row  = 2'(i);
                r.c0   = clip_coef(96'(last_pos[i]));
                r.c1   = clip_coef(m0);
                r.c2   = clip_coef(diff - m0 - cube);
                r.c3   = clip_coef(cube);
                r.last = 1'b0;
                expected_rows.push_back(r);
            end
            dw   = 96'($signed(p.width)) - 96'(last_wid);
            c[3] = 96'($signed(p.spread)) - 2 * dw + 96'(last_spr);
            r.row  = ROW_WIDTH;
            r.c0   = clip_coef(96'(last_wid));
            r.c1   = clip_coef(96'(last_spr));
            r.c2   = clip_coef(dw - 96'(last_spr) - c[3]);
            r.c3   = clip_coef(c[3]);
            r.last = 1'b1;
            expected_rows.push_back(r);
            segments_sent++;
        end
        for (int i = 0; i < 3; i++)
        begin
            last_pos[i] = cur_pos[i];
            last_dir[i] = cur_dir[i];
        end
        last_ten  = p.tension;
        last_wid  = p.width;
        last_spr  = p.spread;
        have_last = 1'b1;
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            3: return 16'($urandom);             // not a unit component: any bits
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
        endcase
    endfunction

    function automatic point_t rand_point(input bit start);
        point_t p;
        p.pos_x = rand_coord(); p.pos_y = rand_coord(); p.pos_z = rand_coord();
        p.dir_x = rand_dir();   p.dir_y = rand_dir();   p.dir_z = rand_dir();
        p.tension = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1024));
        p.width  = rand_coord();
        p.spread = rand_coord();
        p.curve_start = start;
        return p;
    endfunction

    // Fill the queue of pending points: directed cases first, then random curves
    initial
    begin
        point_t p;
        p = '0;
        // no previous point after reset: treated as a curve start
        p.tension = 16'd256; p.dir_x = 16'sd16384;
        pending_points.push_back(p);
        // unit step along x
        p.pos_x = 32'h0001_0000;
        pending_points.push_back(p);
        // zero-length segment
        pending_points.push_back(p);
        // extremes of position, direction and tension: saturation
        p.pos_x = 32'h7fff_ffff; p.pos_y = 32'h8000_0000; p.pos_z = 32'h7fff_ffff;
        p.dir_x = -16'sd16384; p.dir_y = 16'sd16384; p.dir_z = 16'hffff;
        p.tension = 16'hffff; p.width = 32'h7fff_ffff; p.spread = 32'h8000_0000;
        pending_points.push_back(p);
        p.pos_x = 32'h8000_0000; p.pos_y = 32'h7fff_ffff; p.pos_z = 32'h8000_0000;
        p.dir_x = 16'h8000; p.dir_y = 16'h7fff; p.dir_z = 16'sd16384;
        p.width = 32'h8000_0000; p.spread = 32'h7fff_ffff;
        pending_points.push_back(p);
        // explicit curve start mid-stream, then a segment from it
        p = rand_point(1'b1);
        pending_points.push_back(p);
        pending_points.push_back(rand_point(1'b0));
        pending_points.push_back(rand_point(1'b1));
        pending_points.push_back(rand_point(1'b1));
        for (int i = 0; i < 6; i++)
            pending_points.push_back(rand_point(1'b0));
        // random curves: mostly segments, a few starts
        for (int i = 0; i < NUM_RANDOM; i++)
            pending_points.push_back(rand_point($urandom_range(0, 7) == 0));
    end

    // Driver: present pending points, with random idle bursts
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                points_sent++;
                predict_segment(point_t'({s_tuser, s_tdata}));
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    s_tdata  <= p[223:0];
                    s_tuser  <= p.curve_start;
                    s_tvalid <= 1'b1;
                    if (!calm_phase && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 17);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    stim_done = 1'b1;
                end
            end
            calm_phase = (pending_points.size() < 20);
        end
    end

    // Monitor: accept rows with random stall bursts and check them
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                row_t want;
                rows_seen++;
                if (expected_rows.size() == 0)
                begin
                    error_count++;
                    $display("UNEXPECTED row %0d with no segment pending", rows_seen);
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (m_tuser !== want.row)
                        report_mismatch("row_select", m_tuser, want.row);
                    if (m_tdata[39:0] !== want.c0)
                        report_mismatch("coef_const", m_tdata[39:0], want.c0);
                    if (m_tdata[79:40] !== want.c1)
                        report_mismatch("coef_linear", m_tdata[79:40], want.c1);
                    if (m_tdata[119:80] !== want.c2)
                        report_mismatch("coef_square", m_tdata[119:80], want.c2);
                    if (m_tdata[159:120] !== want.c3)
                        report_mismatch("coef_cube", m_tdata[159:120], want.c3);
                    if (m_tlast !== want.last)
                        report_mismatch("last_row", m_tlast, want.last);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 5) == 0)
                    stall_left <= $urandom_range(1, 17);
            end
        end
    end

    // Watchdog: count cycles in which no transaction happens on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        error_count = 0; rows_seen = 0; points_sent = 0; segments_sent = 0;
        idle_cycles = 0; stim_done = 0; calm_phase = 0; have_last = 0;
        last_ten = '0; last_wid = '0; last_spr = '0;
        for (int i = 0; i < 3; i++)
        begin
            last_pos[i] = '0;
            last_dir[i] = '0;
        end
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && expected_rows.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: %0d rows still expected", expected_rows.size());
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            repeat (100) @(posedge clk);
            $display("Sent %0d points forming %0d segments; checked %0d coefficient rows.",
                     points_sent, segments_sent, rows_seen);
            if (error_count == 0 && expected_rows.size() == 0)
                $display("All tests passed");
            else
                $display("Some tests failed");
            $finish;
        end
    end
endmodule

### files.f
+incdir+hdl
hdl/hsc_pkg.sv
hdl/hsc_datapath.sv
hdl/hsc_control.sv
hdl/hermite_segment_coefficients_top.sv
hdl/hsc_checker.sv
dv/tb_top.sv
